// ===== sv/wsfhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame header parser package
// Shared constants and the snapshot type handed from the parser to the
// result stage.
// ----------------------------------------------------------------------------
package wsfhp_pkg;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 32;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [3:0] HDR_LEN_BASE  = 4'd2;
  localparam logic [3:0] HDR_LEN_EXT16 = 4'd4;
  localparam logic [3:0] HDR_LEN_EXT64 = 4'd10;
  localparam logic [3:0] KEY_LEN       = 4'd4;

  localparam logic [2:0] EXT16_OCTETS_M1 = 3'd1;
  localparam logic [2:0] EXT64_OCTETS_M1 = 3'd7;
  localparam logic [2:0] KEY_OCTETS_M1   = 3'd3;

  typedef struct packed {
    logic        done;
    logic        size_valid;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [6:0]  length_code;
    logic [63:0] size;
    logic [31:0] key;
    logic [3:0]  header_length;
  } snap_t;

endpackage
`default_nettype wire

// ===== sv/wsfhp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame header parser channels
// Byte channel into the parser and frame result channel out of it.
// ----------------------------------------------------------------------------
interface wsfhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wsfhp_frame_if;
  logic        valid;
  logic        ready;
  logic        complete;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [6:0]  length_code;
  logic [63:0] payload_len;
  logic [31:0] mask_key;
  logic [3:0]  payload_offset;
  logic [31:0] consumed_length;

  modport source (
    output valid, output complete, output fin, output opcode, output masked,
    output length_code, output payload_len, output mask_key,
    output payload_offset, output consumed_length, input ready
  );
  modport sink (
    input valid, input complete, input fin, input opcode, input masked,
    input length_code, input payload_len, input mask_key,
    input payload_offset, input consumed_length, output ready
  );
endinterface
`default_nettype wire

// ===== sv/wsfhp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame header parser: octet stage
// Registers each octet, advances the header state and, on the final octet,
// captures a snapshot of the decoded header and returns to the start state.
// ----------------------------------------------------------------------------
module wsfhp_parse #(
  parameter int unsigned COUNT_WIDTH = wsfhp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  [7:0]             in_byte_i,
  input  wire                    in_last_i,
  output logic                   snap_valid_o,
  input  wire                    snap_ready_i,
  output wsfhp_pkg::snap_t       snap_o,
  output logic [COUNT_WIDTH-1:0] snap_count_o
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_KEY,
    PH_DONE
  } phase_e;

  logic                   in_vld_q;
  logic [7:0]             in_byte_q;
  logic                   in_last_q;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [2:0]             field_q, field_d;
  logic [63:0]            size_q, size_d;
  logic                   fin_q, fin_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   mask_q, mask_d;
  logic [6:0]             code_q, code_d;
  logic [31:0]            key_q, key_d;
  logic [3:0]             hlen_q, hlen_d;

  logic                   snap_vld_q;
  wsfhp_pkg::snap_t       snap_q;
  logic [COUNT_WIDTH-1:0] snap_count_q;

  logic                   snap_free;
  logic                   take;

  assign snap_free  = !snap_vld_q || snap_ready_i;
  assign take       = in_vld_q && (!in_last_q || snap_free);
  assign in_ready_o = !in_vld_q || take;

  always_comb begin
    phase_d  = phase_q;
    count_d  = (&count_q) ? count_q : count_q + COUNT_WIDTH'(1);
    field_d  = field_q;
    size_d   = size_q;
    fin_d    = fin_q;
    opcode_d = opcode_q;
    mask_d   = mask_q;
    code_d   = code_q;
    key_d    = key_q;
    hlen_d   = hlen_q;
    unique case (phase_q)
      PH_FIRST: begin
        fin_d    = in_byte_q[7];
        opcode_d = in_byte_q[3:0];
        mask_d   = 1'b0;
        code_d   = 7'd0;
        phase_d  = PH_SECOND;
      end
      PH_SECOND: begin
        mask_d = in_byte_q[7];
        code_d = in_byte_q[6:0];
        hlen_d = wsfhp_pkg::HDR_LEN_BASE;
        if (in_byte_q[6:0] == wsfhp_pkg::LEN_CODE_EXT16) begin
          size_d  = 64'd0;
          field_d = wsfhp_pkg::EXT16_OCTETS_M1;
          phase_d = PH_EXTLEN;
        end else if (in_byte_q[6:0] == wsfhp_pkg::LEN_CODE_EXT64) begin
          size_d  = 64'd0;
          field_d = wsfhp_pkg::EXT64_OCTETS_M1;
          phase_d = PH_EXTLEN;
        end else begin
          size_d = 64'(in_byte_q[6:0]);
          if (in_byte_q[7]) begin
            field_d = wsfhp_pkg::KEY_OCTETS_M1;
            phase_d = PH_KEY;
          end else begin
            phase_d = PH_DONE;
          end
        end
      end
      PH_EXTLEN: begin
        size_d = {size_q[55:0], in_byte_q};
        if (field_q == 3'd0) begin
          hlen_d = (code_q == wsfhp_pkg::LEN_CODE_EXT16) ? wsfhp_pkg::HDR_LEN_EXT16
                                                          : wsfhp_pkg::HDR_LEN_EXT64;
          if (mask_q) begin
            field_d = wsfhp_pkg::KEY_OCTETS_M1;
            phase_d = PH_KEY;
          end else begin
            phase_d = PH_DONE;
          end
        end else begin
          field_d = field_q - 3'd1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], in_byte_q};
        if (field_q == 3'd0) begin
          hlen_d  = hlen_q + wsfhp_pkg::KEY_LEN;
          phase_d = PH_DONE;
        end else begin
          field_d = field_q - 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      snap_vld_q <= 1'b0;
      phase_q    <= PH_FIRST;
      count_q    <= '0;
      field_q    <= 3'd0;
      size_q     <= 64'd0;
      fin_q      <= 1'b0;
      opcode_q   <= 4'd0;
      mask_q     <= 1'b0;
      code_q     <= 7'd0;
      key_q      <= 32'd0;
      hlen_q     <= 4'd0;
    end else begin
      if (in_ready_o) begin
        in_vld_q  <= in_valid_i;
        in_byte_q <= in_byte_i;
        in_last_q <= in_last_i;
      end
      if (take && in_last_q) begin
        snap_vld_q <= 1'b1;
      end else if (snap_ready_i) begin
        snap_vld_q <= 1'b0;
      end
      if (take) begin
        if (in_last_q) begin
          snap_q.done               <= (phase_d == PH_DONE);
          snap_q.size_valid         <= (phase_d == PH_DONE) || (phase_d == PH_KEY);
          snap_q.fin                <= fin_d;
          snap_q.opcode             <= opcode_d;
          snap_q.masked             <= mask_d;
          snap_q.length_code        <= code_d;
          snap_q.size               <= size_d;
          snap_q.key                <= key_d;
          snap_q.header_length      <= hlen_d;
          snap_count_q              <= count_d;
          phase_q  <= PH_FIRST;
          count_q  <= '0;
          field_q  <= 3'd0;
          size_q   <= 64'd0;
          fin_q    <= 1'b0;
          opcode_q <= 4'd0;
          mask_q   <= 1'b0;
          code_q   <= 7'd0;
          key_q    <= 32'd0;
          hlen_q   <= 4'd0;
        end else begin
          phase_q  <= phase_d;
          count_q  <= count_d;
          field_q  <= field_d;
          size_q   <= size_d;
          fin_q    <= fin_d;
          opcode_q <= opcode_d;
          mask_q   <= mask_d;
          code_q   <= code_d;
          key_q    <= key_d;
          hlen_q   <= hlen_d;
        end
      end
    end
  end

  assign snap_valid_o = snap_vld_q;
  assign snap_o       = snap_q;
  assign snap_count_o = snap_count_q;

endmodule
`default_nettype wire

// ===== sv/wsfhp_result.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame header parser: result stage
// Checks whether the payload fitted in the buffer, works out the consumed
// length and holds the frame result until it is taken.
// ----------------------------------------------------------------------------
module wsfhp_result #(
  parameter int unsigned COUNT_WIDTH = wsfhp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    snap_valid_i,
  output logic                   snap_ready_o,
  input  wsfhp_pkg::snap_t       snap_i,
  input  wire  [COUNT_WIDTH-1:0] snap_count_i,
  wsfhp_frame_if.source          frame_o
);

  logic                   out_vld_q;
  logic                   complete_q;
  logic                   fin_q;
  logic [3:0]             opcode_q;
  logic                   masked_q;
  logic [6:0]             code_q;
  logic [63:0]            psize_q;
  logic [31:0]            key_q;
  logic [3:0]             offset_q;
  logic [31:0]            consumed_q;

  logic [COUNT_WIDTH-1:0] remaining;
  logic [63:0]            psize;
  logic                   complete;

  assign remaining    = snap_count_i - COUNT_WIDTH'(snap_i.header_length);
  assign psize        = snap_i.size_valid ? snap_i.size : 64'd0;
  assign complete     = snap_i.done && (psize <= 64'(remaining));
  assign snap_ready_o = !out_vld_q || frame_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (snap_ready_o) begin
      out_vld_q  <= snap_valid_i;
      complete_q <= complete;
      fin_q      <= snap_i.fin;
      opcode_q   <= snap_i.opcode;
      masked_q   <= snap_i.masked;
      code_q     <= snap_i.length_code;
      psize_q    <= psize;
      key_q      <= (snap_i.done && snap_i.masked) ? snap_i.key : 32'd0;
      offset_q   <= snap_i.done ? snap_i.header_length : 4'd0;
      consumed_q <= complete ? psize[31:0] + 32'(snap_i.header_length) : 32'd0;
    end
  end

  assign frame_o.valid           = out_vld_q;
  assign frame_o.complete        = complete_q;
  assign frame_o.fin             = fin_q;
  assign frame_o.opcode          = opcode_q;
  assign frame_o.masked          = masked_q;
  assign frame_o.length_code     = code_q;
  assign frame_o.payload_len     = psize_q;
  assign frame_o.mask_key        = key_q;
  assign frame_o.payload_offset  = offset_q;
  assign frame_o.consumed_length = consumed_q;

endmodule
`default_nettype wire

// ===== sv/websocket_frame_header_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame header parser
// Decodes the header of one frame from a buffer delivered one octet per
// transfer, and reports the header fields and consumed length on the final
// octet.
//
//   Channel   Direction  Contents
//   byte_i    in         data_byte, last_byte (one octet per transfer)
//   frame_o   out        decoded header, payload offset, consumed length
//
// One octet is taken every cycle while no final octet waits for the snapshot;
// the header state advances as each octet is taken. The final octet passes
// through the input register, the snapshot register and the result register,
// where the length check is applied, in that order.
// Reset clears all control state and the parser expects a first octet.
// A stalled result holds the pipeline back only once the snapshot is full.
// ----------------------------------------------------------------------------
module websocket_frame_header_parse #(
  parameter int unsigned COUNT_WIDTH = wsfhp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  wsfhp_byte_if.sink    byte_i,
  wsfhp_frame_if.source frame_o
);

  logic                   snap_valid;
  logic                   snap_ready;
  wsfhp_pkg::snap_t       snap;
  logic [COUNT_WIDTH-1:0] snap_count;

  wsfhp_parse #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .in_ready_o   (byte_i.ready),
    .in_byte_i    (byte_i.data_byte),
    .in_last_i    (byte_i.last_byte),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap),
    .snap_count_o (snap_count)
  );

  wsfhp_result #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .snap_count_i (snap_count),
    .frame_o      (frame_o)
  );

endmodule
`default_nettype wire

// ===== tb/websocket_frame_header_parse_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame header parser regression
// Sends received buffers one octet per transfer, predicts the decoded header,
// payload offset and consumed length for each final octet, and compares every
// result transfer with the oldest prediction. Directed buffers cover truncated
// headers, every length form, masking and trailing octets; random frames with
// random truncation follow, with and without idle cycles on both channels.
// ----------------------------------------------------------------------------
module websocket_frame_header_parse_test;

  localparam int unsigned CW = wsfhp_pkg::COUNT_WIDTH_DEFAULT;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef enum logic [2:0] {
    AWAIT_FIRST,
    AWAIT_SECOND,
    EXT_LENGTH,
    MASK_KEY,
    HEADER_DONE
  } parse_phase_e;

  typedef struct packed {
    logic        complete;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [6:0]  length_code;
    logic [63:0] payload_len;
    logic [31:0] mask_key;
    logic [3:0]  payload_offset;
    logic [31:0] consumed_length;
  } frame_report_t;

  logic clk_i;
  logic rst_ni;

  wsfhp_byte_if  octet_ch ();
  wsfhp_frame_if report_ch ();

  websocket_frame_header_parse dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (octet_ch),
    .frame_o (report_ch)
  );

  parse_phase_e    rx_phase;
  logic [CW-1:0]   octets_seen;
  logic [2:0]      octets_left;
  logic [63:0]     size_acc;
  logic            hdr_fin;
  logic [3:0]      hdr_opcode;
  logic            hdr_masked;
  logic [6:0]      hdr_code;
  logic [31:0]     key_acc;
  logic [3:0]      hdr_len;

  frame_report_t   pending_reports[$];
  logic [7:0]      frame_octets[$];
  int              error_count = 0;
  int              octets_sent = 0;
  bit              idle_enabled = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_parser();
    rx_phase    = AWAIT_FIRST;
    octets_seen = '0;
    octets_left = '0;
    size_acc    = '0;
    hdr_fin     = 1'b0;
    hdr_opcode  = '0;
    hdr_masked  = 1'b0;
    hdr_code    = '0;
    key_acc     = '0;
    hdr_len     = '0;
  endfunction

  function automatic void enter_key_or_done();
    if (hdr_masked) begin
      rx_phase    = MASK_KEY;
      octets_left = wsfhp_pkg::KEY_OCTETS_M1;
    end else begin
      rx_phase = HEADER_DONE;
    end
  endfunction

  function automatic bit decode_octet(input logic [7:0] b, input logic last,
                                      output frame_report_t rpt);
    logic        done;
    logic [63:0] psize;
    logic [63:0] room;
    logic [63:0] total;
    rpt = '0;
    if (octets_seen != '1) octets_seen = octets_seen + 1'b1;
    case (rx_phase)
      AWAIT_FIRST: begin
        hdr_fin    = b[7];
        hdr_opcode = b[3:0];
        hdr_masked = 1'b0;
        hdr_code   = '0;
        rx_phase   = AWAIT_SECOND;
      end
      AWAIT_SECOND: begin
        hdr_masked = b[7];
        hdr_code   = b[6:0];
        hdr_len    = wsfhp_pkg::HDR_LEN_BASE;
        if (hdr_code == wsfhp_pkg::LEN_CODE_EXT16) begin
          size_acc    = '0;
          octets_left = wsfhp_pkg::EXT16_OCTETS_M1;
          rx_phase    = EXT_LENGTH;
        end else if (hdr_code == wsfhp_pkg::LEN_CODE_EXT64) begin
          size_acc    = '0;
          octets_left = wsfhp_pkg::EXT64_OCTETS_M1;
          rx_phase    = EXT_LENGTH;
        end else begin
          size_acc = {57'b0, hdr_code};
          enter_key_or_done();
        end
      end
      EXT_LENGTH: begin
        size_acc = {size_acc[55:0], b};
        if (octets_left == 3'd0) begin
          hdr_len = (hdr_code == wsfhp_pkg::LEN_CODE_EXT16) ? wsfhp_pkg::HDR_LEN_EXT16
                                                             : wsfhp_pkg::HDR_LEN_EXT64;
          enter_key_or_done();
        end else begin
          octets_left = octets_left - 1'b1;
        end
      end
      MASK_KEY: begin
        key_acc = {key_acc[23:0], b};
        if (octets_left == 3'd0) begin
          hdr_len  = hdr_len + wsfhp_pkg::KEY_LEN;
          rx_phase = HEADER_DONE;
        end else begin
          octets_left = octets_left - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!last) return 1'b0;
    done  = (rx_phase == HEADER_DONE);
    psize = (done || rx_phase == MASK_KEY) ? size_acc : 64'd0;
    room  = 64'(octets_seen) - {60'b0, hdr_len};
    total = {60'b0, hdr_len} + psize;
    rpt.fin          = hdr_fin;
    rpt.opcode       = hdr_opcode;
    rpt.masked       = hdr_masked;
    rpt.length_code  = hdr_code;
    rpt.payload_len  = psize;
    rpt.mask_key     = (done && hdr_masked) ? key_acc : 32'd0;
    rpt.payload_offset = done ? hdr_len : 4'd0;
    if (done && psize <= room) begin
      rpt.complete        = 1'b1;
      rpt.consumed_length = total[31:0];
    end
    clear_parser();
    return 1'b1;
  endfunction

  task automatic send_octet(input logic [7:0] b, input logic last);
    frame_report_t rpt;
    while (idle_enabled && $urandom_range(0, 99) < 15) begin
      octet_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    octet_ch.valid     = 1'b1;
    octet_ch.data_byte = b;
    octet_ch.last_byte = last;
    @(posedge clk_i);
    while (!octet_ch.ready) @(posedge clk_i);
    if (decode_octet(b, last, rpt)) pending_reports.push_back(rpt);
    octets_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_octets.size(); i++) begin
      send_octet(frame_octets[i], i == frame_octets.size() - 1);
    end
  endtask

  task automatic build_random_frame();
    int          sel;
    int          mode;
    int          cut;
    int          pay_n;
    int          header_n;
    logic [63:0] size;
    logic [6:0]  code;
    logic        mask;
    mask = 1'($urandom_range(0, 1));
    sel  = $urandom_range(0, 9);
    if (sel < 6) begin
      size = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 125))
                                         : 64'($urandom_range(0, 12));
      code = size[6:0];
    end else if (sel < 8) begin
      code = wsfhp_pkg::LEN_CODE_EXT16;
      size = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 65535))
                                         : 64'($urandom_range(0, 24));
    end else begin
      code = wsfhp_pkg::LEN_CODE_EXT64;
      size = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                         : 64'($urandom_range(0, 24));
    end
    frame_octets.delete();
    frame_octets.push_back(8'($urandom));
    frame_octets.push_back({mask, code});
    if (code == wsfhp_pkg::LEN_CODE_EXT16) begin
      frame_octets.push_back(size[15:8]);
      frame_octets.push_back(size[7:0]);
    end else if (code == wsfhp_pkg::LEN_CODE_EXT64) begin
      for (int i = 7; i >= 0; i--) frame_octets.push_back(size[i*8 +: 8]);
    end
    if (mask) begin
      for (int i = 0; i < 4; i++) frame_octets.push_back(8'($urandom));
    end
    header_n = frame_octets.size();
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      cut = $urandom_range(1, header_n - 1);
      while (frame_octets.size() > cut) void'(frame_octets.pop_back());
      pay_n = 0;
    end else if (mode < 4 && size != 0) begin
      pay_n = (size <= 40) ? $urandom_range(0, int'(size) - 1) : $urandom_range(0, 40);
    end else if (size <= 125) begin
      pay_n = int'(size) + ((mode >= 8) ? $urandom_range(1, 4) : 0);
    end else begin
      pay_n = $urandom_range(0, 16);
    end
    for (int i = 0; i < pay_n; i++) frame_octets.push_back(8'($urandom));
  endtask

  task automatic send_random_buffers(input int count);
    int stop_at;
    int n;
    stop_at = octets_sent + count;
    while (octets_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        frame_octets.delete();
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) frame_octets.push_back(8'($urandom));
      end else begin
        build_random_frame();
      end
      send_frame();
    end
  endtask

  task automatic test_truncated_headers();
    frame_octets = {8'h81};
    send_frame();
    frame_octets = {8'hff, 8'hfe};
    send_frame();
  endtask

  task automatic test_short_lengths();
    frame_octets = {8'h0f, 8'h00};
    send_frame();
    frame_octets = {8'h70, 8'h7d};
    send_frame();
  endtask

  task automatic test_extended_lengths();
    frame_octets = {8'h80, 8'h7e, 8'h00, 8'h01, 8'haa};
    send_frame();
    frame_octets = {8'h01, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff,
                    8'hff, 8'hff, 8'hff, 8'hff};
    send_frame();
  endtask

  task automatic test_masked_frames();
    frame_octets = {8'h82, 8'h81, 8'hde, 8'had, 8'hbe, 8'hef, 8'h55};
    send_frame();
    frame_octets = {8'h89, 8'h80, 8'h12, 8'h34};
    send_frame();
  endtask

  task automatic test_trailing_octets();
    frame_octets = {8'h8a, 8'h00, 8'h01, 8'h02};
    send_frame();
  endtask

  task automatic test_random_frames();
    idle_enabled = 1'b1;
    send_random_buffers(420);
  endtask

  task automatic test_back_to_back_frames();
    idle_enabled = 1'b0;
    send_random_buffers(180);
    idle_enabled = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [63:0] expd,
                             input logic [63:0] act);
    if (expd !== act) begin
      $error("%s: expected %0h, actual %0h", name, expd, act);
      error_count++;
    end
  endtask

  initial begin
    report_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      report_ch.ready = !(idle_enabled && $urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk_i) begin
    frame_report_t want;
    if (rst_ni && report_ch.valid && report_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("Result transfer with no prediction waiting.");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("complete", 64'(want.complete), 64'(report_ch.complete));
        check_field("fin", 64'(want.fin), 64'(report_ch.fin));
        check_field("opcode", 64'(want.opcode), 64'(report_ch.opcode));
        check_field("masked", 64'(want.masked), 64'(report_ch.masked));
        check_field("length_code", 64'(want.length_code), 64'(report_ch.length_code));
        check_field("payload_len", want.payload_len, report_ch.payload_len);
        check_field("mask_key", 64'(want.mask_key), 64'(report_ch.mask_key));
        check_field("payload_offset", 64'(want.payload_offset),
                    64'(report_ch.payload_offset));
        check_field("consumed_length", 64'(want.consumed_length),
                    64'(report_ch.consumed_length));
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((octet_ch.valid && octet_ch.ready) || (report_ch.valid && report_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("websocket_frame_header_parse regression: fail");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    octet_ch.valid     = 1'b0;
    octet_ch.data_byte = '0;
    octet_ch.last_byte = 1'b0;
    clear_parser();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_truncated_headers();
    test_short_lengths();
    test_extended_lengths();
    test_masked_frames();
    test_trailing_octets();
    test_random_frames();
    test_back_to_back_frames();

    octet_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("websocket_frame_header_parse regression: pass");
    end else begin
      $display("websocket_frame_header_parse regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wsfhp_pkg.sv
sv/wsfhp_if.sv
sv/wsfhp_parse.sv
sv/wsfhp_result.sv
sv/websocket_frame_header_parse.sv
tb/websocket_frame_header_parse_test.sv
